@@ hw/rtl/bvc_pkg.sv @@
// Shared types and codes for the bitmap video colorizer.
// No dependencies; every other RTL file of the block except bvc_ram imports this package.
`default_nettype none

package bvc_pkg;

  localparam int COLOR_ENTRIES_DEF = 2048;
  localparam int FIFO_DEPTH_DEF    = 4;

  // Action codes of an input item
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_RENDER = 2'd2;

  // Color mode codes; codes above MODE_PALETTE color like MODE_WHITE
  localparam logic [2:0] MODE_WHITE   = 3'd0;
  localparam logic [2:0] MODE_GREEN   = 3'd1;
  localparam logic [2:0] MODE_BAND_A  = 3'd2;
  localparam logic [2:0] MODE_BAND_B  = 3'd3;
  localparam logic [2:0] MODE_PALETTE = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [12:0] ram_offset;
    logic [7:0]  write_data;
    logic [7:0]  video_byte;
    logic [7:0]  pixel_row;
    logic [4:0]  byte_column;
  } item_t;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] read_data;
    logic       last;
  } result_t;

  // One classified job between the front and back ends
  typedef struct packed {
    logic       is_read;
    logic [7:0] ram_data;
    logic [7:0] video_byte;
    logic [7:0] pixel_row;
    logic [4:0] byte_column;
  } job_t;

endpackage

`default_nettype wire

@@ hw/rtl/bitmap_video_colorizer.sv @@
// Top level of the bitmap video colorizer: mode register, front end, job queue, back end.
// Depends on bvc_pkg, bvc_front (with bvc_ram), bvc_fifo and bvc_back.
//
// Usage:
//   Input channel is queue-like: drive item and raise push; the item is taken at a
//   clock edge where push is high and full is low. Actions: write color RAM (no
//   result), read color RAM (one beat with read_data), render one video byte (eight
//   pixel beats, bit 0 first, last set on the eighth).
//   Result channel: while empty is low the oldest beat sits on result; it is taken
//   at an edge where pop is high. Hold pop low to stall; the back end then freezes
//   while the front end keeps taking items until the job queue fills.
//   Path: the first beat of an item passes the color RAM read, the job queue, the
//   back-end register and the output register.
//   Throughput: items enter one per cycle while full is low; the back end emits one beat
//   per cycle unless pop stalls it. The pixel loop in the back end sets that rate; writes
//   finish in the front end and cost the back end nothing.
//   The user must write color_mode (mode_we/mode_data) only while the block is idle; not enforced.
//   Reset (rst, synchronous): color_mode goes to white, queue and output empty.
//   The color RAM is not cleared; its entries are undefined until written.
`default_nettype none

module bitmap_video_colorizer
  import bvc_pkg::*;
#(
  parameter int COLOR_ENTRIES = COLOR_ENTRIES_DEF,
  parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire item_t      item,
  output logic            full,
  output result_t         result,
  output logic            empty,
  input  wire logic       pop,
  input  wire logic       mode_we,
  input  wire logic [2:0] mode_data
);

  localparam int CW = $clog2(FIFO_DEPTH+1);

  logic [2:0]    color_mode;
  logic          job_push;
  job_t          job;
  job_t          head;
  logic          fifo_pop;
  logic [CW-1:0] fifo_count;

  // Hold the color mode; the user must write it only between items, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= MODE_WHITE;
    end else if (mode_we) begin
      color_mode <= mode_data;
    end
  end

  // Accept items, touch the color RAM, classify into jobs
  bvc_front #(
    .COLOR_ENTRIES (COLOR_ENTRIES),
    .FIFO_DEPTH    (FIFO_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .fifo_count (fifo_count),
    .job_push   (job_push),
    .job        (job)
  );

  // Decouple the two ends so each can stall on its own
  bvc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (fifo_pop),
    .head     (head),
    .count    (fifo_count)
  );

  // Expand jobs into result beats
  bvc_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .color_mode (color_mode),
    .head       (head),
    .fifo_count (fifo_count),
    .fifo_pop   (fifo_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire

@@ hw/rtl/bvc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/bvc_fifo.sv @@
// Short job queue between the front and back ends of the colorizer.
// Depends on bvc_pkg for the job type.
`default_nettype none

module bvc_fifo
  import bvc_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire job_t                       push_job,
  input  wire logic                       pop,
  output job_t                            head,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH-1)) ? '0 : p + PW'(1);
  endfunction

  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bvc_front.sv @@
// Front end: accepts items, folds color RAM offsets, does RAM access and queues jobs.
// Depends on bvc_pkg and bvc_ram.
`default_nettype none

module bvc_front
  import bvc_pkg::*;
#(
  parameter int COLOR_ENTRIES = COLOR_ENTRIES_DEF,
  parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire item_t                           item,
  output logic                                 full,
  input  wire logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count,
  output logic                                 job_push,
  output job_t                                 job
);

  localparam int AW = $clog2(COLOR_ENTRIES);
  localparam int CW = $clog2(FIFO_DEPTH+1);

  logic                 accept;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [12:0]          offset;
  logic [7:0]           ram_rdata;
  logic                 stage_valid;
  job_t                 stage_job;

  // Fold offset bits 12:7 down onto entry bits 10:5, keep bits 4:0
  function automatic logic [AW-1:0] fold_index(logic [12:0] off);
    logic [10:0] idx;
    idx = {off[12:7], off[4:0]};
    return AW'(idx);
  endfunction

  // Leave room for the job already held in the stage register
  assign full = (fifo_count == CW'(FIFO_DEPTH)) ||
                (stage_valid && fifo_count == CW'(FIFO_DEPTH-1));
  assign accept = push && !full;

  assign offset   = (item.action == ACT_RENDER) ? {item.pixel_row, item.byte_column}
                                                : item.ram_offset;
  assign ram_addr = fold_index(offset);
  assign ram_we   = accept && item.action == ACT_WRITE;

  bvc_ram #(
    .WIDTH (8),
    .DEPTH (COLOR_ENTRIES)
  ) u_color_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (item.write_data),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept && (item.action == ACT_READ || item.action == ACT_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_job.is_read     <= (item.action == ACT_READ);
      stage_job.ram_data    <= '0;
      stage_job.video_byte  <= item.video_byte;
      stage_job.pixel_row   <= item.pixel_row;
      stage_job.byte_column <= item.byte_column;
    end
  end

  always_comb begin
    job          = stage_job;
    job.ram_data = ram_rdata;
  end
  assign job_push = stage_valid;

`ifndef SYNTHESIS
  a_write_no_job: assert property (@(posedge clk) disable iff (rst)
    accept && item.action == ACT_WRITE |=> !stage_valid)
    else $error("write action produced a queued job");

  a_job_follows: assert property (@(posedge clk) disable iff (rst)
    accept && (item.action == ACT_READ || item.action == ACT_RENDER) |=> stage_valid)
    else $error("read or render action lost before the queue");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    stage_valid |-> fifo_count < CW'(FIFO_DEPTH))
    else $error("job pushed into a full queue");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/bvc_back.sv @@
// Back end: expands queued jobs into results, one per cycle unless pop stalls the output, through an output register.
// Depends on bvc_pkg.
`default_nettype none

module bvc_back
  import bvc_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [2:0]                      color_mode,
  input  wire job_t                            head,
  input  wire logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count,
  output logic                                 fifo_pop,
  output result_t                              result,
  output logic                                 empty,
  input  wire logic                            pop
);

  logic        cur_valid;
  job_t        cur;
  logic [2:0]  bit_idx;
  logic        out_valid;
  logic        advance;
  logic        cur_last;
  logic        have_job;
  logic [7:0]  px;
  logic [7:0]  py;
  logic [23:0] rgb;
  result_t     pix;

  function automatic logic [23:0] palette_rgb(logic [2:0] idx);
    logic [23:0] c;
    case (idx)
      3'd0:    c = {8'd128, 8'd128, 8'd255};
      3'd1:    c = {8'd255, 8'd0,   8'd0};
      3'd2:    c = {8'd0,   8'd0,   8'd255};
      3'd3:    c = {8'd255, 8'd0,   8'd255};
      3'd4:    c = {8'd0,   8'd255, 8'd0};
      3'd5:    c = {8'd255, 8'd255, 8'd0};
      3'd6:    c = {8'd0,   8'd255, 8'd255};
      default: c = {8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

  assign have_job = fifo_count != '0;
  assign advance  = !out_valid || pop;
  assign cur_last = cur.is_read || bit_idx == 3'd7;
  assign fifo_pop = have_job && (!cur_valid || (advance && cur_last));
  assign empty    = !out_valid;

  assign px = {cur.byte_column, bit_idx};
  assign py = cur.pixel_row;

  always_comb begin
    if (!cur.video_byte[bit_idx]) begin
      rgb = '0;
    end else begin
      unique case (color_mode)
        MODE_GREEN: rgb = {8'd51, 8'd255, 8'd127};
        MODE_BAND_A: begin
          if (px > 8'd194 && px <= 8'd223) begin
            rgb = {8'd255, 8'd32, 8'd32};
          end else if (px >= 8'd16 && px <= 8'd72) begin
            rgb = {8'd32, 8'd255, 8'd32};
          end else if (px < 8'd16 && py >= 8'd16 && py < 8'd134) begin
            rgb = {8'd32, 8'd255, 8'd32};
          end else begin
            rgb = {8'd255, 8'd255, 8'd255};
          end
        end
        MODE_BAND_B: begin
          if (px > 8'd192) begin
            rgb = {8'd38, 8'd255, 8'd38};
          end else if (px < 8'd73) begin
            rgb = {8'd255, 8'd255, 8'd38};
          end else begin
            rgb = {8'd255, 8'd128, 8'd255};
          end
        end
        MODE_PALETTE: rgb = palette_rgb(cur.ram_data[2:0]);
        default:      rgb = {8'd255, 8'd255, 8'd255};
      endcase
    end
  end

  always_comb begin
    if (cur.is_read) begin
      pix           = '0;
      pix.read_data = cur.ram_data;
      pix.last      = 1'b1;
    end else begin
      pix.pixel_x   = px;
      pix.pixel_y   = py;
      pix.red       = rgb[23:16];
      pix.green     = rgb[15:8];
      pix.blue      = rgb[7:0];
      pix.read_data = '0;
      pix.last      = (bit_idx == 3'd7);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      bit_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fifo_pop) begin
        cur_valid <= 1'b1;
        bit_idx   <= '0;
      end else if (advance && cur_valid) begin
        if (cur_last) begin
          cur_valid <= 1'b0;
        end
        bit_idx <= bit_idx + 3'd1;
      end
      if (advance) begin
        out_valid <= cur_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      cur <= head;
    end
    if (advance && cur_valid) begin
      result <= pix;
    end
  end

`ifndef SYNTHESIS
  a_read_single: assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur.is_read |-> bit_idx == 3'd0)
    else $error("read job stepped past its single result");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    cur_valid && !cur_last && !advance |=> cur_valid && $stable(bit_idx))
    else $error("pixel step moved while output stalled");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> fifo_count != '0)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire
